// ===== rtl/jsbe_pkg.sv =====
// shared types, constants and helpers of the json string byte escaper
`timescale 1ns / 1ps
`default_nettype none
package jsbe_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int SEQ_IDX_BITS = 3;

   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_FF     = 8'h0c;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_AMP    = 8'h26;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LOW_B  = 8'h62;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6e;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_LOW_U  = 8'h75;
   localparam logic [7:0] CHAR_DEL    = 8'h7f;

   localparam logic [7:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   // positions inside an escape sequence
   localparam logic [SEQ_IDX_BITS-1:0] SEQ_FIRST   = 3'd0;
   localparam logic [SEQ_IDX_BITS-1:0] SEQ_SECOND  = 3'd1;
   localparam logic [SEQ_IDX_BITS-1:0] SEQ_THIRD   = 3'd2;
   localparam logic [SEQ_IDX_BITS-1:0] SEQ_FOURTH  = 3'd3;
   localparam logic [SEQ_IDX_BITS-1:0] SEQ_HEX_HI  = 3'd4;
   localparam logic [SEQ_IDX_BITS-1:0] SEQ_HEX_LO  = 3'd5;

   typedef logic [LENGTH_BITS-1:0] len_type;

   typedef enum logic [1:0] {
      ESC_PASS    = 2'd0,
      ESC_SHORT   = 2'd1,
      ESC_UNICODE = 2'd2
   } esc_kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last_of_item;
      logic        last_of_string;
      logic [31:0] total_length;
   } rsp_type;

   // one classified item between front and back
   typedef struct packed {
      esc_kind_type kind;
      logic [7:0]   data;
      logic         eos;
   } esc_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = HEX_DIGITS[nib];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/json_string_byte_escaper_unit.sv =====
// top level of the json string byte escaper
`timescale 1ns / 1ps
`default_nettype none
// Escapes one raw string byte per input transfer into its JSON form of one, two
// or six output bytes, one output transfer per cycle from a registered output
// while rsp_stall is low. A plain byte gives one byte, a short escape two and a
// \u00xx escape six; the back end's output byte sequencer emits them in order,
// and a four-entry queue lets input transfers continue while a long escape
// drains. html_safe is written through the csr port, which is always ready,
// and should change only when idle. total_length counts output bytes of the
// current string, saturating, and restarts after the byte marked end_of_string.
module json_string_byte_escaper_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire jsbe_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output jsbe_pkg::rsp_type      rsp_data
);

   logic queue_full;
   logic push;
   jsbe_pkg::esc_type push_entry;
   logic pop;
   logic head_valid;
   jsbe_pkg::esc_type head_entry;

   jsbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   jsbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   jsbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/jsbe_front.sv =====
// front end: html_safe register, input transfer and byte classification
`timescale 1ns / 1ps
`default_nettype none
module jsbe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire jsbe_pkg::req_type req_data,
   input  wire logic             queue_full,
   output logic                  push,
   output jsbe_pkg::esc_type     push_entry
);

   logic html_safe_ff;
   logic html_safe_in;
   logic [7:0] b;
   logic amp_escape;

   assign csr_ready = 1'b1;
   assign html_safe_in = (csr_valid && csr_ready) ? csr_data : html_safe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         html_safe_ff <= 1'b0;
      end else begin
         html_safe_ff <= html_safe_in;
      end
   end

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;
   assign b = req_data.in_byte;
   assign amp_escape = html_safe_ff && (b == jsbe_pkg::CHAR_AMP);

   always_comb begin
      push_entry.eos = req_data.end_of_string;
      push_entry.data = b;
      push_entry.kind = jsbe_pkg::ESC_PASS;
      if (b == jsbe_pkg::CHAR_DEL || b < jsbe_pkg::CHAR_SPACE || b == jsbe_pkg::CHAR_QUOTE
          || b == jsbe_pkg::CHAR_BSLASH || amp_escape) begin
         push_entry.kind = jsbe_pkg::ESC_SHORT;
         case (b)
            jsbe_pkg::CHAR_BS: begin
               push_entry.data = jsbe_pkg::CHAR_LOW_B;
            end
            jsbe_pkg::CHAR_FF: begin
               push_entry.data = jsbe_pkg::CHAR_LOW_F;
            end
            jsbe_pkg::CHAR_LF: begin
               push_entry.data = jsbe_pkg::CHAR_LOW_N;
            end
            jsbe_pkg::CHAR_CR: begin
               push_entry.data = jsbe_pkg::CHAR_LOW_R;
            end
            jsbe_pkg::CHAR_TAB: begin
               push_entry.data = jsbe_pkg::CHAR_LOW_T;
            end
            jsbe_pkg::CHAR_BSLASH, jsbe_pkg::CHAR_QUOTE: begin
               push_entry.data = b;
            end
            default: begin
               push_entry.kind = jsbe_pkg::ESC_UNICODE;
               push_entry.data = b;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/jsbe_queue.sv =====
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none
module jsbe_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire jsbe_pkg::esc_type push_entry,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output jsbe_pkg::esc_type      head_entry
);

   localparam logic [jsbe_pkg::QUEUE_PTR_BITS-1:0] PTR_LAST =
      jsbe_pkg::QUEUE_PTR_BITS'(jsbe_pkg::QUEUE_DEPTH - 1);
   localparam logic [jsbe_pkg::QUEUE_CNT_BITS-1:0] CNT_FULL =
      jsbe_pkg::QUEUE_CNT_BITS'(jsbe_pkg::QUEUE_DEPTH);

   jsbe_pkg::esc_type entries_ff [jsbe_pkg::QUEUE_DEPTH];
   logic [jsbe_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsbe_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsbe_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/jsbe_back.sv =====
// back end: expands one queued item into its output bytes and keeps the length
`timescale 1ns / 1ps
`default_nettype none
module jsbe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire jsbe_pkg::esc_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output jsbe_pkg::rsp_type      rsp_data
);

   logic [jsbe_pkg::SEQ_IDX_BITS-1:0] idx_ff, idx_in;
   jsbe_pkg::len_type len_ff, len_in, len_inc;
   logic rsp_valid_ff, rsp_valid_in;
   jsbe_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic load;
   logic last;
   logic [7:0] seq_byte;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      seq_byte = head_entry.data;
      last = 1'b1;
      case (head_entry.kind)
         jsbe_pkg::ESC_PASS: begin
            seq_byte = head_entry.data;
            last = 1'b1;
         end
         jsbe_pkg::ESC_SHORT: begin
            seq_byte = (idx_ff == jsbe_pkg::SEQ_FIRST) ? jsbe_pkg::CHAR_BSLASH : head_entry.data;
            last = (idx_ff == jsbe_pkg::SEQ_SECOND);
         end
         jsbe_pkg::ESC_UNICODE: begin
            last = (idx_ff == jsbe_pkg::SEQ_HEX_LO);
            case (idx_ff)
               jsbe_pkg::SEQ_FIRST: begin
                  seq_byte = jsbe_pkg::CHAR_BSLASH;
               end
               jsbe_pkg::SEQ_SECOND: begin
                  seq_byte = jsbe_pkg::CHAR_LOW_U;
               end
               jsbe_pkg::SEQ_THIRD, jsbe_pkg::SEQ_FOURTH: begin
                  seq_byte = jsbe_pkg::CHAR_ZERO;
               end
               jsbe_pkg::SEQ_HEX_HI: begin
                  seq_byte = jsbe_pkg::hex_char(head_entry.data[7:4]);
               end
               default: begin
                  seq_byte = jsbe_pkg::hex_char(head_entry.data[3:0]);
               end
            endcase
         end
         default: begin
            seq_byte = head_entry.data;
            last = 1'b1;
         end
      endcase
   end

   assign pop = load && last;
   assign len_inc = (len_ff == '1) ? len_ff : len_ff + 1'b1;

   always_comb begin
      idx_in = idx_ff;
      len_in = len_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in = last ? '0 : idx_ff + 1'b1;
         len_in = (last && head_entry.eos) ? '0 : len_inc;
         rsp_data_in.out_byte = seq_byte;
         rsp_data_in.last_of_item = last;
         rsp_data_in.last_of_string = last && head_entry.eos;
         rsp_data_in.total_length = 32'(len_inc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         len_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         len_ff <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire
